// File: sv/krt_pkg.sv
// Shared types and constants for the keyed record table.
// Used by the interfaces, the controller, the datapath and the top level.
package krt_pkg;

  localparam int KRT_DEPTH = 16;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int SAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int TOTAL_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  // How the datapath closes out a command.
  localparam int FIN_W = 3;
  localparam logic [FIN_W-1:0] FIN_ADD   = 3'd0;
  localparam logic [FIN_W-1:0] FIN_EMPTY = 3'd1;
  localparam logic [FIN_W-1:0] FIN_MISS  = 3'd2;
  localparam logic [FIN_W-1:0] FIN_FOUND = 3'd3;
  localparam logic [FIN_W-1:0] FIN_DEL   = 3'd4;

  typedef struct packed {
    logic             load;
    logic             walk;
    logic             shift;
    logic             start_shift;
    logic             finish;
    logic [FIN_W-1:0] fin;
  } krt_cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_del;
    logic is_empty;
    logic hit;
    logic miss;
    logic shift_done;
  } krt_stat_t;

endpackage

// File: sv/krt_in_if.sv
// Command channel of the keyed record table: valid/ready plus the command fields.
// Depends on krt_pkg for the field widths.
interface krt_in_if;
  import krt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  record_id;
  logic [SAL_W-1:0]  salary;

  modport source (output valid, kind, record_id, salary, input ready);
  modport sink   (input valid, kind, record_id, salary, output ready);
endinterface

// File: sv/krt_out_if.sv
// Response channel of the keyed record table: valid/ready plus the result fields.
// Depends on krt_pkg for the field widths.
interface krt_out_if;
  import krt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [SAL_W-1:0]    out_salary;
  logic [TOTAL_W-1:0]  entry_total;

  modport source (output valid, status, slot, out_salary, entry_total, input ready);
  modport sink   (input valid, status, slot, out_salary, entry_total, output ready);
endinterface

// File: sv/krt_ctrl.sv
// Controller for the keyed record table: sequences accept, search, shift and response.
// Depends on krt_pkg for the command and status structs.
module krt_ctrl import krt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  krt_stat_t stat,
  output krt_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // A new response may be written when the output register is empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fin    = FIN_ADD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_add) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            cmd.fin    = FIN_ADD;
            state_next = S_IDLE;
          end
        end else if (stat.is_del && stat.is_empty) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            cmd.fin    = FIN_EMPTY;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.hit) begin
          if (stat.is_del) begin
            cmd.start_shift = 1'b1;
            state_next      = S_SHIFT;
          end else if (out_free) begin
            cmd.finish = 1'b1;
            cmd.fin    = FIN_FOUND;
            state_next = S_IDLE;
          end
        end else if (stat.miss) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            cmd.fin    = FIN_MISS;
            state_next = S_IDLE;
          end
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_SHIFT: begin
        if (!stat.shift_done) begin
          cmd.shift = 1'b1;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          cmd.fin    = FIN_DEL;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/krt_dp.sv
// Datapath for the keyed record table: record memories, count, walk pointer and
// response registers. Depends on krt_pkg; driven by krt_ctrl.
module krt_dp import krt_pkg::*; #(
  parameter int DEPTH = KRT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_W-1:0]    cfg_wdata,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [SAL_W-1:0]    in_salary,
  input  krt_cmd_t            cmd,
  output krt_stat_t           stat,
  output logic [STATUS_W-1:0] res_status,
  output logic [SLOT_W-1:0]   res_slot,
  output logic [SAL_W-1:0]    res_salary,
  output logic [TOTAL_W-1:0]  res_total
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [SAL_W-1:0] val_mem [DEPTH];

  logic [CAP_W-1:0]  capacity;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [SAL_W-1:0]  sal;
  logic [CW-1:0]     idx;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic [KEY_W-1:0]  rd_key;
  logic [SAL_W-1:0]  rd_val;
  logic [AW-1:0]     pos;
  logic [SAL_W-1:0]  hval;

  logic              rd_go;
  logic              rd_en;
  logic              full;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [KEY_W-1:0]  wr_key;
  logic [SAL_W-1:0]  wr_val;
  logic [STATUS_W-1:0] fin_status;
  logic [AW-1:0]     fin_slot;
  logic [SAL_W-1:0]  fin_salary;

  assign rd_go = (idx < count);
  assign rd_en = (cmd.walk || cmd.shift) && rd_go;
  assign full  = (XW'(count) >= XW'(capacity)) || (count >= CW'(DEPTH));

  assign stat.is_add     = (kind == KIND_ADD);
  assign stat.is_del     = (kind == KIND_DELETE);
  assign stat.is_empty   = (count == '0);
  assign stat.hit        = pend && (rd_key == key);
  assign stat.miss       = !(pend && (rd_key == key)) && !rd_go;
  assign stat.shift_done = !rd_go && !pend;

  // Memory write port: shift moves, appends and salary updates never coincide.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = pend_idx - AW'(1);
    wr_key  = rd_key;
    wr_val  = rd_val;
    if (cmd.shift && pend) begin
      mem_we = 1'b1;
    end
    if (cmd.finish && cmd.fin == FIN_ADD && !full) begin
      mem_we  = 1'b1;
      wr_addr = AW'(count);
      wr_key  = key;
      wr_val  = sal;
    end
    if (cmd.finish && cmd.fin == FIN_FOUND && kind == KIND_UPDATE) begin
      mem_we  = 1'b1;
      wr_addr = pend_idx;
      wr_key  = rd_key;
      wr_val  = sal;
    end
  end

  always_comb begin
    fin_status = ST_OK;
    fin_slot   = '0;
    fin_salary = '0;
    count_next = count;
    case (cmd.fin)
      FIN_ADD: begin
        if (full) begin
          fin_status = ST_FULL;
        end else begin
          fin_slot   = AW'(count);
          fin_salary = sal;
          count_next = count + CW'(1);
        end
      end
      FIN_EMPTY: fin_status = ST_EMPTY;
      FIN_MISS:  fin_status = ST_MISSING;
      FIN_FOUND: begin
        fin_slot   = pend_idx;
        fin_salary = (kind == KIND_UPDATE) ? sal : rd_val;
      end
      FIN_DEL: begin
        fin_slot   = pos;
        fin_salary = hval;
        count_next = count - CW'(1);
      end
      default: fin_status = ST_MISSING;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key <= key_mem[AW'(idx)];
      rd_val <= val_mem[AW'(idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
      idx      <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.finish) begin
        count <= count_next;
      end
      if (cmd.load) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.start_shift) begin
        idx  <= CW'(pend_idx) + CW'(1);
        pend <= 1'b0;
      end else if (cmd.walk || cmd.shift) begin
        if (rd_go) begin
          idx  <= idx + CW'(1);
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_kind;
      key  <= in_key;
      sal  <= in_salary;
    end
    if ((cmd.walk || cmd.shift) && rd_go) begin
      pend_idx <= AW'(idx);
    end
    if (cmd.start_shift) begin
      pos  <= pend_idx;
      hval <= rd_val;
    end
    if (cmd.finish) begin
      res_status <= fin_status;
      res_slot   <= SLOT_W'(fin_slot);
      res_salary <= fin_salary;
      res_total  <= TOTAL_W'(count_next);
    end
  end

endmodule

// File: sv/keyed_record_table.sv
// Keyed record table top level: an unsorted table of id/salary records held in
// a single-port-write memory, one command at a time. Add and delete-on-empty
// finish without a search; search, update and delete walk the table with a
// linear search, which reads one slot per cycle. A delete then moves every
// record behind the removed one down by one slot. The next command is accepted
// while the previous response still waits to be taken.
// Depends on krt_pkg, krt_in_if, krt_out_if, krt_ctrl and krt_dp.
module keyed_record_table import krt_pkg::*; #(
  parameter int DEPTH = KRT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  krt_in_if.sink           req,
  krt_out_if.source        rsp
);

  krt_cmd_t  cmd;
  krt_stat_t stat;

  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  krt_dp #(.DEPTH(DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (req.kind),
    .in_key     (req.record_id),
    .in_salary  (req.salary),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (rsp.status),
    .res_slot   (rsp.slot),
    .res_salary (rsp.out_salary),
    .res_total  (rsp.entry_total)
  );

endmodule

// File: verif/keyed_record_table_test.sv
// Self-checking testbench for keyed_record_table: drives commands on the request channel,
// predicts every response from a local copy of the table and compares it field by field.
// Depends on krt_pkg, krt_in_if, krt_out_if and the keyed_record_table RTL.
module keyed_record_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_WAIT  = 50;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SAL_W-1:0]    salary;
    logic [TOTAL_W-1:0]  total;
  } table_reply_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  krt_in_if  req_if();
  krt_out_if rsp_if();

  keyed_record_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // Local copy of the table contents and the capacity register.
  logic [KEY_W-1:0]   table_ids [KRT_DEPTH];
  logic [SAL_W-1:0]   table_salaries [KRT_DEPTH];
  int                 table_count;
  logic [CAP_W-1:0]   capacity_setting;

  table_reply_t       pending_replies [$];
  int                 mismatch_count;
  int                 cycle_count;
  int                 hold_left;
  int                 stall_left;
  bit                 quiet;
  bit                 sender_idle_on;
  logic [KEY_W-1:0]   key_pool [8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic table_reply_t predict_reply(input logic [KIND_W-1:0] kind,
                                                 input logic [KEY_W-1:0] id,
                                                 input logic [SAL_W-1:0] sal);
    table_reply_t r;
    int limit;
    int pos;
    r.status = ST_OK;
    r.slot   = '0;
    r.salary = '0;
    limit = (capacity_setting < KRT_DEPTH) ? int'(capacity_setting) : KRT_DEPTH;
    if (kind == KIND_ADD) begin
      if (table_count >= limit) begin
        r.status = ST_FULL;
      end else begin
        r.slot = table_count[SLOT_W-1:0];
        table_ids[table_count] = id;
        table_salaries[table_count] = sal;
        r.salary = sal;
        table_count++;
      end
    end else if (kind == KIND_DELETE && table_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pos = -1;
      for (int i = 0; i < table_count; i++) begin
        if (pos < 0 && table_ids[i] == id) pos = i;
      end
      if (pos < 0) begin
        r.status = ST_MISSING;
      end else begin
        r.slot = pos[SLOT_W-1:0];
        if (kind == KIND_UPDATE) table_salaries[pos] = sal;
        r.salary = table_salaries[pos];
        if (kind == KIND_DELETE) begin
          for (int i = pos; i + 1 < table_count; i++) begin
            table_ids[i] = table_ids[i + 1];
            table_salaries[i] = table_salaries[i + 1];
          end
          table_count--;
        end
      end
    end
    r.total = table_count[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic send_command(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] id,
                              input logic [SAL_W-1:0] sal);
    @(negedge clk);
    req_if.valid     = 1'b1;
    req_if.kind      = kind;
    req_if.record_id = id;
    req_if.salary    = sal;
    do @(posedge clk); while (!req_if.ready);
    pending_replies.push_back(predict_reply(kind, id, sal));
  endtask

  task automatic sender_idle(input int n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
  endtask

  // Stop offering and wait until every outstanding response has been taken.
  task automatic drain_replies();
    sender_idle(1);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_replies();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    capacity_setting = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] expected_value,
                             input logic [31:0] actual_value);
    if (expected_value !== actual_value) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name,
               expected_value, actual_value);
    end
  endtask

  // Response checker: every transaction on the response channel is compared
  // with the oldest prediction.
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected response, expected none, actual status %h slot %h",
                 $realtime, rsp_if.status, rsp_if.slot);
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_if.status));
        check_field("slot", 32'(want.slot), 32'(rsp_if.slot));
        check_field("out_salary", want.salary, rsp_if.out_salary);
        check_field("entry_total", 32'(want.total), 32'(rsp_if.entry_total));
      end
    end
  end

  // Response ready: a long hold when requested, else random stall bursts.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready = 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_command(KIND_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_command(KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(KIND_DELETE, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Leaves two records behind: FFFFFFFF then the duplicate of id 0.
  task automatic test_basic_ops();
    send_command(KIND_ADD, 32'h0000_0000, 32'h0000_0000);
    send_command(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(KIND_ADD, 32'h0000_0000, 32'h1234_5678);
    send_command(KIND_ADD, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_command(KIND_SEARCH, 32'h0000_0000, 32'hDEAD_BEEF);
    send_command(KIND_SEARCH, 32'hA5A5_A5A5, 32'h0000_0000);
    send_command(KIND_UPDATE, 32'h0000_0000, 32'hCAFE_F00D);
    send_command(KIND_UPDATE, 32'h1357_9BDF, 32'h1111_1111);
    send_command(KIND_DELETE, 32'h2468_ACE0, 32'h0000_0000);
    send_command(KIND_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_command(KIND_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_command(KIND_DELETE, 32'hA5A5_A5A5, 32'h0000_0000);
  endtask

  task automatic test_capacity_limits();
    write_capacity(5'd2);
    send_command(KIND_ADD, 32'h0000_0042, 32'h0000_0001);
    // Capacity below the current count: records stay, adds report full.
    write_capacity(5'd1);
    send_command(KIND_ADD, 32'h0000_0043, 32'h0000_0002);
    send_command(KIND_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_command(KIND_ADD, 32'h0000_0044, 32'h0000_0003);
    send_command(KIND_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_command(KIND_ADD, 32'h0000_0045, 32'h0000_0004);
    send_command(KIND_ADD, 32'h0000_0046, 32'h0000_0005);
    write_capacity(5'd0);
    send_command(KIND_DELETE, 32'h0000_0045, 32'h0000_0000);
    send_command(KIND_ADD, 32'h0000_0047, 32'h0000_0006);
    write_capacity(5'd31);
  endtask

  task automatic fill_key_pool();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
  endtask

  task automatic send_random_command(input bit add_heavy);
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  id;
    logic [SAL_W-1:0]  sal;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < (add_heavy ? 60 : 20)) kind = KIND_ADD;
    else if (pick < (add_heavy ? 73 : 45)) kind = KIND_SEARCH;
    else if (pick < (add_heavy ? 87 : 75)) kind = KIND_DELETE;
    else kind = KIND_UPDATE;
    id = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : 32'($urandom);
    case ($urandom_range(0, 9))
      0: sal = 32'h0000_0000;
      1: sal = 32'hFFFF_FFFF;
      default: sal = $urandom;
    endcase
    send_command(kind, id, sal);
  endtask

  // The block takes one command while a response waits, so a long hold on
  // the response side backs up the request side quickly.
  task automatic test_backpressure();
    fill_key_pool();
    hold_left = 300;
    repeat (14) send_random_command(1'b1);
    drain_replies();
  endtask

  task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int n);
    bit add_heavy;
    write_capacity(cap);
    fill_key_pool();
    add_heavy = 1'b1;
    for (int i = 0; i < n; i++) begin
      // Alternate between filling and emptying so both ends of the table are hit.
      if (i % 30 == 29) add_heavy = !add_heavy;
      send_random_command(add_heavy);
      if (sender_idle_on && $urandom_range(0, 7) == 0) sender_idle($urandom_range(1, 6));
    end
  endtask

  task automatic test_random();
    logic [CAP_W-1:0] caps [7];
    int per_phase;
    caps = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd0, 5'd12, CAP_W'($urandom_range(0, 31))};
    per_phase = RANDOM_ITEMS / 8;
    sender_idle_on = 1'b1;
    foreach (caps[i]) test_random_phase(caps[i], per_phase);
    // Closing stretch with no idling on either side.
    drain_replies();
    quiet = 1'b1;
    sender_idle_on = 1'b0;
    test_random_phase(5'd16, per_phase);
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_if.valid     = 1'b0;
    req_if.kind      = KIND_ADD;
    req_if.record_id = '0;
    req_if.salary    = '0;
    capacity_setting = CAP_RESET;
    table_count      = 0;
    mismatch_count   = 0;
    cycle_count      = 0;
    hold_left        = 0;
    stall_left       = 0;
    quiet            = 1'b0;
    sender_idle_on   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_basic_ops();
    test_capacity_limits();
    test_backpressure();
    test_random();

    drain_replies();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
